>>> hw/rtl/radix_digit_converter_core_macros.svh
// assertion macros for the radix digit converter
`ifndef RADIX_DIGIT_CONVERTER_CORE_MACROS_SVH
`define RADIX_DIGIT_CONVERTER_CORE_MACROS_SVH

// same-cycle implication
`define RDC_ASSERT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define RDC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hw/rtl/rdc_pkg.sv
// shared types, constants and helpers for the radix digit converter
package rdc_pkg;

	localparam int VALUE_WIDTH_DEF = 64;
	localparam int MAX_DIGITS_DEF  = 64;

	localparam int DIGIT_W = 6;
	localparam int CHAR_W  = 7;

	localparam logic [DIGIT_W-1:0] RADIX_MIN   = 6'd2;
	localparam logic [DIGIT_W-1:0] RADIX_MAX   = 6'd36;
	localparam logic [DIGIT_W-1:0] RADIX_RESET = 6'd10;
	localparam logic [DIGIT_W-1:0] DIGIT_TEN   = 6'd10;

	localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
	localparam logic [CHAR_W-1:0] CHAR_UPPER = 7'h41;
	localparam logic [CHAR_W-1:0] CHAR_LOWER = 7'h61;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 7;
	localparam logic [CFG_IDX_W-1:0] REG_RADIX      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_UPPER_CASE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_DIGITS = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic               clear;
		logic               shift;
		logic [DIGIT_W-1:0] radix;
	} cell_ctrl_t;

	function automatic logic [CHAR_W-1:0] ascii_of(input logic [DIGIT_W-1:0] d,
			input logic upper);
		logic [CHAR_W-1:0] dx;
		dx = {1'b0, d};
		if (d < DIGIT_TEN) begin
			return CHAR_ZERO + dx;
		end else if (upper) begin
			return CHAR_UPPER + (dx - {1'b0, DIGIT_TEN});
		end else begin
			return CHAR_LOWER + (dx - {1'b0, DIGIT_TEN});
		end
	endfunction

endpackage

>>> hw/rtl/rdc_cell.sv
// digit cell: doubles digit, adds incoming bit, passes carry; or shifts a digit in
module rdc_cell import rdc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  cell_ctrl_t         ctrl,
	input  logic               carry_in,
	input  logic               valid_in,
	input  logic [DIGIT_W-1:0] digit_in,
	output logic               carry_q,
	output logic               valid_q,
	output logic [DIGIT_W-1:0] digit_q
);

	logic [DIGIT_W:0]   dbl;
	logic               wrap;
	logic [DIGIT_W-1:0] digit_nxt;

	always_comb begin
		dbl       = {digit_q, carry_in};
		wrap      = dbl >= {1'b0, ctrl.radix};
		digit_nxt = wrap ? DIGIT_W'(dbl - {1'b0, ctrl.radix}) : dbl[DIGIT_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digit_q <= '0;
			carry_q <= 1'b0;
			valid_q <= 1'b0;
		end else if (ctrl.clear) begin
			digit_q <= '0;
			carry_q <= 1'b0;
			valid_q <= 1'b0;
		end else if (ctrl.shift) begin
			digit_q <= digit_in;
			carry_q <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			valid_q <= valid_in;
			if (valid_in) begin
				digit_q <= digit_nxt;
				carry_q <= wrap;
			end else begin
				carry_q <= 1'b0;
			end
		end
	end

endmodule

>>> hw/rtl/radix_digit_converter_core.sv
// top level: unsigned binary value to ascii digits in base 2 to 36
// conversion: value bits enter a row of MAX_DIGITS digit cells msb first, and the carry wave
//   ripples along the row until all digits settle
// output: the row then shifts out from the top, one character a cycle while the output is not stalled
//   once the leading digit is reached; a new value is taken only after its last character is issued
// reset: asynchronous, active low; registers back to radix 10, lower case, no padding, idle
`include "radix_digit_converter_core_macros.svh"
module radix_digit_converter_core import rdc_pkg::*; #(
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
	parameter int MAX_DIGITS  = MAX_DIGITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [63:0]           s_tdata,   // value
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [7:0]            m_tdata,   // digit_char, zero pad
	output logic                  m_tlast,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int CNT_W = $clog2(VALUE_WIDTH + MAX_DIGITS);
	localparam int POS_W = $clog2(MAX_DIGITS);

	state_t state_q, state_nxt;

	logic [DIGIT_W-1:0]     cfg_radix_q;
	logic                   cfg_upper_q;
	logic [CFG_DATA_W-1:0]  cfg_min_q;

	logic [DIGIT_W-1:0]     job_radix_q;
	logic                   job_upper_q;
	logic [CFG_DATA_W-1:0]  job_pad_q;
	logic [VALUE_WIDTH-1:0] val_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [POS_W-1:0]       pos_q;
	logic                   started_q;
	logic                   ovf_q;

	logic                   m_tvalid_q;
	logic [CHAR_W-1:0]      char_q;
	logic                   last_q;

	logic                   in_acc;
	logic                   feed_v;
	logic                   conv_done;
	logic                   out_free;
	logic                   emit;
	logic                   advance;
	logic                   pos_zero;
	logic [DIGIT_W-1:0]     top_digit;
	logic [DIGIT_W-1:0]     radix_clamped;
	cell_ctrl_t             ctrl;

	logic [DIGIT_W-1:0]     digit_w [MAX_DIGITS];
	logic                   carry_w [MAX_DIGITS];
	logic                   valid_w [MAX_DIGITS];

	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = {1'b0, char_q};
	assign m_tlast   = last_q;

	assign in_acc    = s_tvalid && s_tready;
	assign top_digit = digit_w[MAX_DIGITS-1];
	assign pos_zero  = pos_q == '0;
	assign out_free  = !m_tvalid_q || m_tready;

	always_comb begin
		if (cfg_radix_q < RADIX_MIN) begin
			radix_clamped = RADIX_MIN;
		end else if (cfg_radix_q > RADIX_MAX) begin
			radix_clamped = RADIX_MAX;
		end else begin
			radix_clamped = cfg_radix_q;
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) state_nxt = ST_CONV;
			end
			ST_CONV: begin
				if (conv_done) state_nxt = ST_EMIT;
			end
			ST_EMIT: begin
				if (advance && pos_zero) state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		s_tready  = 1'b0;
		feed_v    = 1'b0;
		conv_done = 1'b0;
		emit      = 1'b0;
		advance   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
			end
			ST_CONV: begin
				feed_v    = cnt_q < CNT_W'(VALUE_WIDTH);
				conv_done = cnt_q == CNT_W'(VALUE_WIDTH + MAX_DIGITS - 1);
			end
			ST_EMIT: begin
				emit = started_q || ovf_q || (top_digit != '0) || pos_zero
					|| ({{(8 - POS_W){1'b0}}, pos_q} < {1'b0, job_pad_q});
				advance = !emit || out_free;
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

	always_comb begin
		ctrl.clear = in_acc;
		ctrl.shift = advance;
		ctrl.radix = job_radix_q;
	end

	// row of digit cells, least significant digit at index zero
	for (genvar k = 0; k < MAX_DIGITS; k++) begin : g_cell
		if (k == 0) begin : g_head
			rdc_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.ctrl     (ctrl),
				.carry_in (val_q[VALUE_WIDTH-1]),
				.valid_in (feed_v),
				.digit_in ('0),
				.carry_q  (carry_w[k]),
				.valid_q  (valid_w[k]),
				.digit_q  (digit_w[k])
			);
		end else begin : g_body
			rdc_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.ctrl     (ctrl),
				.carry_in (carry_w[k-1]),
				.valid_in (valid_w[k-1]),
				.digit_in (digit_w[k-1]),
				.carry_q  (carry_w[k]),
				.valid_q  (valid_w[k]),
				.digit_q  (digit_w[k])
			);
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_radix_q <= RADIX_RESET;
			cfg_upper_q <= 1'b0;
			cfg_min_q   <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_RADIX:      cfg_radix_q <= cfg_data[DIGIT_W-1:0];
				REG_UPPER_CASE: cfg_upper_q <= cfg_data[0];
				REG_MIN_DIGITS: cfg_min_q   <= cfg_data;
				default:        ;
			endcase
		end
	end

	// sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= '0;
			pos_q     <= '0;
			started_q <= 1'b0;
			ovf_q     <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (in_acc) begin
				cnt_q     <= '0;
				pos_q     <= POS_W'(MAX_DIGITS - 1);
				started_q <= 1'b0;
				ovf_q     <= 1'b0;
			end else if (state_q == ST_CONV) begin
				cnt_q <= cnt_q + 1'b1;
				ovf_q <= ovf_q | carry_w[MAX_DIGITS-1];
			end else if (advance) begin
				pos_q     <= pos_q - 1'b1;
				started_q <= started_q | emit;
			end
		end
	end

	// per-item payload registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			job_radix_q <= radix_clamped;
			job_upper_q <= cfg_upper_q;
			job_pad_q   <= cfg_min_q;
			val_q       <= s_tdata[VALUE_WIDTH-1:0];
		end else if (feed_v) begin
			val_q <= {val_q[VALUE_WIDTH-2:0], 1'b0};
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (advance && emit) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			char_q <= ascii_of(top_digit, job_upper_q);
			last_q <= pos_zero;
		end
	end

	`RDC_ASSERT_NEXT(a_no_char_in_conv, (state_q == ST_CONV) && out_free, !m_tvalid_q, "character issued during conversion")
	`RDC_ASSERT(a_digit_below_radix, state_q == ST_EMIT, top_digit < job_radix_q, "digit out of range for radix")
	`RDC_ASSERT(a_ovf_only_when_short, ovf_q, MAX_DIGITS < VALUE_WIDTH, "digit row overflow with full capacity")

endmodule

>>> verif/radix_digit_converter_core_tb.sv
`timescale 1ns / 1ps
// testbench for radix_digit_converter_core: directed table, then random values checked per character
module radix_digit_converter_core_tb;
	import rdc_pkg::*;

	localparam int MAX_DIG     = MAX_DIGITS_DEF;
	localparam int CYCLE_LIMIT = 2_000_000;
	localparam int PHASES      = 8;
	localparam int PHASE_ITEMS = 44;
	localparam int TAIL_CYCLES = VALUE_WIDTH_DEF + 2 * MAX_DIG + 16;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam logic [63:0] ALL_ONES = '1;

	typedef enum logic {
		ROW_WRITE,
		ROW_ITEM
	} row_kind_t;

	typedef struct {
		row_kind_t              kind;
		logic [CFG_IDX_W-1:0]   idx;
		logic [CFG_DATA_W-1:0]  data;
		logic [63:0]            value;
		string                  want;
	} stim_row_t;

	typedef struct packed {
		logic [CHAR_W-1:0] ch;
		logic              last;
	} char_beat_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [63:0]           s_tdata = '0;   // value
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [7:0]            m_tdata;        // digit_char, zero pad
	logic                  m_tlast;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// configuration as the block should hold it
	logic [DIGIT_W-1:0]    cur_radix = RADIX_RESET;
	logic                  cur_upper = 1'b0;
	logic [CFG_DATA_W-1:0] cur_min = '0;

	char_beat_t pending_chars[$];
	char_beat_t head_beat;
	int         mismatches = 0;
	int         cycles = 0;
	int         tx_gap_pct = 0;
	int         rx_stall_pct = 0;
	int         rx_stall_left = 0;
	logic       quiet_tail = 1'b0;

	// rows with a typed string are checked against it, items with an empty string go through the predictor
	stim_row_t dir_rows[$] = '{
		'{ROW_ITEM,  REG_RADIX,      7'd0,   64'd0,      "0"},
		'{ROW_ITEM,  REG_RADIX,      7'd0,   64'd1,      "1"},
		'{ROW_ITEM,  REG_RADIX,      7'd0,   ALL_ONES,   "18446744073709551615"},
		'{ROW_ITEM,  REG_RADIX,      7'd0,   64'd10,     "10"},
		'{ROW_WRITE, REG_RADIX,      7'd16,  64'd0,      ""},
		'{ROW_ITEM,  REG_RADIX,      7'd0,   64'd255,    "ff"},
		'{ROW_ITEM,  REG_RADIX,      7'd0,   ALL_ONES,   "ffffffffffffffff"},
		'{ROW_WRITE, REG_UPPER_CASE, 7'd1,   64'd0,      ""},
		'{ROW_ITEM,  REG_RADIX,      7'd0,   64'hABCDEF, "ABCDEF"},
		'{ROW_WRITE, REG_RADIX,      7'd36,  64'd0,      ""},
		'{ROW_ITEM,  REG_RADIX,      7'd0,   64'd35,     "Z"},
		'{ROW_ITEM,  REG_RADIX,      7'd0,   64'd36,     "10"},
		'{ROW_ITEM,  REG_RADIX,      7'd0,   ALL_ONES,   ""},
		'{ROW_WRITE, REG_MIN_DIGITS, 7'd3,   64'd0,      ""},
		'{ROW_WRITE, REG_RADIX,      7'd0,   64'd0,      ""},
		'{ROW_ITEM,  REG_RADIX,      7'd0,   64'd6,      "110"},
		'{ROW_ITEM,  REG_RADIX,      7'd0,   64'd1,      "001"},
		'{ROW_WRITE, REG_RADIX,      7'd1,   64'd0,      ""},
		'{ROW_ITEM,  REG_RADIX,      7'd0,   64'd2,      "010"},
		'{ROW_WRITE, REG_RADIX,      7'd63,  64'd0,      ""},
		'{ROW_WRITE, REG_UPPER_CASE, 7'd0,   64'd0,      ""},
		'{ROW_ITEM,  REG_RADIX,      7'd0,   64'd35,     "00z"},
		'{ROW_WRITE, REG_RADIX,      7'd37,  64'd0,      ""},
		'{ROW_ITEM,  REG_RADIX,      7'd0,   64'd36,     "010"},
		'{ROW_WRITE, REG_MIN_DIGITS, 7'd127, 64'd0,      ""},
		'{ROW_ITEM,  REG_RADIX,      7'd0,   ALL_ONES,   ""},
		'{ROW_WRITE, REG_RADIX,      7'd2,   64'd0,      ""},
		'{ROW_WRITE, REG_MIN_DIGITS, 7'd64,  64'd0,      ""},
		'{ROW_ITEM,  REG_RADIX,      7'd0,   ALL_ONES,   ""},
		'{ROW_ITEM,  REG_RADIX,      7'd0,   64'd0,      ""},
		'{ROW_WRITE, REG_MIN_DIGITS, 7'd0,   64'd0,      ""},
		'{ROW_WRITE, REG_RADIX,      7'd10,  64'd0,      ""},
		'{ROW_WRITE, REG_UNUSED,     7'd127, 64'd0,      ""},
		'{ROW_ITEM,  REG_RADIX,      7'd0,   64'd12345,  "12345"}
	};

	radix_digit_converter_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// digits of v in the current base, most significant first, padded with zeros
	function automatic void predict_digits(input logic [63:0] v);
		logic [DIGIT_W-1:0] digs [MAX_DIG];
		logic [63:0]        rest;
		logic [63:0]        base;
		logic [CHAR_W-1:0]  ch;
		int                 n;
		int                 pad;
		int                 width;
		int                 pos;
		base = 64'(cur_radix);
		if (base < 64'(RADIX_MIN)) base = 64'(RADIX_MIN);
		if (base > 64'(RADIX_MAX)) base = 64'(RADIX_MAX);
		pad = int'(cur_min);
		if (pad > MAX_DIG) pad = MAX_DIG;
		rest = v;
		n = 0;
		do begin
			digs[n] = DIGIT_W'(rest % base);
			rest = rest / base;
			n++;
		end while (rest != 0 && n < MAX_DIG);
		width = (n > pad) ? n : pad;
		for (int k = 0; k < width; k++) begin
			pos = width - 1 - k;
			if (pos >= n) begin
				ch = CHAR_ZERO;
			end else if (digs[pos] < DIGIT_TEN) begin
				ch = CHAR_ZERO + CHAR_W'(digs[pos]);
			end else begin
				ch = (cur_upper ? CHAR_UPPER : CHAR_LOWER) + CHAR_W'(digs[pos] - DIGIT_TEN);
			end
			pending_chars.push_back('{ch, k == width - 1});
		end
	endfunction

	// stop sending and wait for every outstanding character
	task automatic settle();
		if (s_tvalid) s_tvalid <= 1'b0;
		while (pending_chars.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		settle();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_RADIX:      cur_radix = data[DIGIT_W-1:0];
			REG_UPPER_CASE: cur_upper = data[0];
			REG_MIN_DIGITS: cur_min = data;
			default:        ;
		endcase
	endtask

	task automatic send_value(input logic [63:0] v, input string want);
		int gap;
		if (cfg_valid) cfg_valid <= 1'b0;
		gap = ($urandom_range(0, 99) < tx_gap_pct) ? $urandom_range(1, 14) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= v;
		do @(posedge clk); while (!s_tready);
		if (want.len() != 0) begin
			for (int k = 0; k < want.len(); k++)
				pending_chars.push_back('{CHAR_W'(want[k]), k == want.len() - 1});
		end else begin
			predict_digits(v);
		end
	endtask

	// output side: check each transaction and stall in bursts
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_chars.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected character: tdata %h tlast %b", m_tdata, m_tlast);
			end else begin
				head_beat = pending_chars.pop_front();
				if (m_tdata !== {1'b0, head_beat.ch} || m_tlast !== head_beat.last) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected tdata %h tlast %b, got tdata %h tlast %b",
							{1'b0, head_beat.ch}, head_beat.last, m_tdata, m_tlast);
				end
			end
		end
		if (rx_stall_left > 0) begin
			rx_stall_left--;
			m_tready <= 1'b0;
		end else if (!quiet_tail && $urandom_range(0, 99) < rx_stall_pct) begin
			rx_stall_left = $urandom_range(0, 13);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	initial begin
		logic [63:0]           v;
		logic [CFG_DATA_W-1:0] word;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		tx_gap_pct   = 30;
		rx_stall_pct = 30;
		foreach (dir_rows[i]) begin
			if (dir_rows[i].kind == ROW_WRITE)
				write_reg(dir_rows[i].idx, dir_rows[i].data);
			else
				send_value(dir_rows[i].value, dir_rows[i].want);
		end

		for (int p = 0; p < PHASES; p++) begin
			quiet_tail = (p == PHASES - 1);
			tx_gap_pct   = quiet_tail ? 0 : 20 * $urandom_range(0, 2);
			rx_stall_pct = quiet_tail ? 0 : 20 * $urandom_range(0, 2);
			case ($urandom_range(0, 5))
				0:       word = 7'd2;
				1:       word = 7'd36;
				2:       word = 7'd10;
				3:       word = 7'd16;
				4:       word = CFG_DATA_W'($urandom_range(0, 127));
				default: word = CFG_DATA_W'($urandom_range(2, 36));
			endcase
			write_reg(REG_RADIX, word);
			write_reg(REG_UPPER_CASE, CFG_DATA_W'($urandom_range(0, 1)));
			word = ($urandom_range(0, 4) == 0) ? CFG_DATA_W'($urandom_range(0, 127))
				: CFG_DATA_W'($urandom_range(0, 6));
			write_reg(REG_MIN_DIGITS, word);
			if ($urandom_range(0, 3) == 0)
				write_reg(REG_UNUSED, CFG_DATA_W'($urandom_range(0, 127)));
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				case ($urandom_range(0, 5))
					0, 1, 2: v = {$urandom, $urandom};
					3:       v = {$urandom, $urandom} >> $urandom_range(1, 63);
					4:       v = 64'($urandom_range(0, 1000));
					default: v = $urandom_range(0, 1) ? ALL_ONES : 64'd0;
				endcase
				send_value(v, "");
			end
		end

		settle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
